/* hw/rtl/coalescing_deferred_call_queue_assert.svh */
// Assertion macros for the coalescing deferred-call queue checker.
// Needs aclk and aresetn visible in the scope of each use.
`ifndef COALESCING_DEFERRED_CALL_QUEUE_ASSERT_SVH
`define COALESCING_DEFERRED_CALL_QUEUE_ASSERT_SVH

// Same-cycle implication, skipped while reset is asserted.
`define CDCQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define CDCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cdcq_pkg.sv */
// Shared types and constants of the coalescing deferred-call queue.
// No dependencies; used by the top level and the port checker.
package cdcq_pkg;

    localparam int HANDLER_W = 16;
    localparam int ARG_W     = 32;
    localparam int ENTRY_W   = HANDLER_W + ARG_W;
    localparam int STATUS_W  = 3;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 56;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_QUEUED    = 3'd0,
        STATUS_COALESCED = 3'd1,
        STATUS_OVERFLOW  = 3'd2,
        STATUS_DELIVERED = 3'd3,
        STATUS_EMPTY     = 3'd4
    } status_t;

    // Input command codes.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DRAIN   = 1'b1;

endpackage

/* hw/rtl/cdcq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdcq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/coalescing_deferred_call_queue.sv */
// Coalescing deferred-call queue: top level with sequencer and scan compare.
// Depends on cdcq_pkg and cdcq_ram.
// Usage
//   s_* channel: one beat is a command. s_tuser[0] selects enqueue (0) or
//     drain (1); s_tdata carries handler id and argument.
//   m_* channel: result beats. m_tuser holds the status code, m_tdata the
//     delivered handler/argument and the soft interrupt request flag,
//     m_tlast marks the final result of a command.
//   cfg_we/cfg_wdata: write reissue_always; write only while idle.
// Operation
//   An enqueue reads the queued entries from the entry RAM in order, oldest
//   first, through one comparator, and stops at the first match. A drain of
//   N entries streams one beat per cycle while m_tready does not stall it,
//   after the registered RAM read; an empty drain gives its single beat.
//   s_tready is high only between commands, so one command is in flight
//   at a time.
// Reset and stall
//   Synchronous active-low reset empties the queue and sets reissue_always;
//   entry storage is not cleared. A stalled m_tready holds the output beat;
//   drain and result steps wait for it, while a scan keeps running.
module coalescing_deferred_call_queue
    import cdcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_wdata,   // reissue_always
    // command stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // [15:0] handler_id, [47:16] argument
    input  logic [0:0]          s_tuser,     // [0] command
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,     // [15:0] out_handler,
                                             // [47:16] out_argument,
                                             // [48] soft_int_request, [55:49] zero
    output logic [STATUS_W-1:0] m_tuser,     // [2:0] status
    output logic                m_tlast      // last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [ENTRY_W-1:0]  key_reg;
    status_t             res_status_reg;
    logic                reissue_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    status_t             m_status_reg;
    logic                m_last_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                key_match;
    logic                queue_full;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic                sir;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        next_slot = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign out_load   = out_free && ((state_reg == ST_DRAIN) || (state_reg == ST_RESULT));
    // single comparator: one stored entry per cycle against the held key
    assign key_match  = (rd_data == key_reg);
    assign queue_full = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Read the oldest entry on accept, then walk forward one slot per read.
    always_comb begin
        rd_addr = (state_reg == ST_IDLE) ? head_reg : pos_reg;
        case (state_reg)
            ST_IDLE:  rd_en = accept && (count_reg != '0);
            ST_SCAN:  rd_en = !key_match && (rem_reg != CNT_W'(1));
            ST_DRAIN: rd_en = out_free && (rem_reg != CNT_W'(1));
            default:  rd_en = 1'b0;
        endcase
    end

    // Append only when the result beat for a new pair leaves.
    assign wr_en = (state_reg == ST_RESULT) && out_free
                   && (res_status_reg == STATUS_QUEUED);

    always_comb begin
        case (res_status_reg)
            STATUS_QUEUED:    sir = (count_reg == '0) || reissue_reg;
            STATUS_COALESCED: sir = reissue_reg;
            default:          sir = 1'b0;
        endcase
    end

    cdcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            reissue_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                reissue_reg <= cfg_wdata;
            end
            // raise valid on a new load, drop the beat once taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg <= {s_tdata[HANDLER_W +: ARG_W], s_tdata[HANDLER_W-1:0]};
                        pos_reg <= next_slot(head_reg);
                        rem_reg <= count_reg;
                        if (count_reg == '0) begin
                            res_status_reg <= (s_tuser[0] == CMD_DRAIN) ? STATUS_EMPTY
                                                                        : STATUS_QUEUED;
                            state_reg      <= ST_RESULT;
                        end else if (s_tuser[0] == CMD_DRAIN) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    if (key_match) begin
                        res_status_reg <= STATUS_COALESCED;
                        state_reg      <= ST_RESULT;
                    end else if (rem_reg == CNT_W'(1)) begin
                        res_status_reg <= queue_full ? STATUS_OVERFLOW : STATUS_QUEUED;
                        state_reg      <= ST_RESULT;
                    end else begin
                        // advance to the next stored entry
                        pos_reg <= next_slot(pos_reg);
                        rem_reg <= rem_reg - CNT_W'(1);
                    end
                end

                ST_DRAIN: begin
                    if (out_free) begin
                        m_status_reg <= STATUS_DELIVERED;
                        m_data_reg   <= M_DATA_W'(rd_data);
                        m_last_reg   <= (rem_reg == CNT_W'(1));
                        if (rem_reg == CNT_W'(1)) begin
                            head_reg  <= tail_reg;
                            count_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg <= next_slot(pos_reg);
                            rem_reg <= rem_reg - CNT_W'(1);
                        end
                    end
                end

                ST_RESULT: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_data_reg   <= {{(M_DATA_W - ENTRY_W - 1){1'b0}}, sir,
                                         {ENTRY_W{1'b0}}};
                        m_last_reg   <= 1'b1;
                        if (res_status_reg == STATUS_QUEUED) begin
                            tail_reg  <= next_slot(tail_reg);
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hw/rtl/cdcq_checker.sv */
// Port-level checker for the coalescing deferred-call queue, with its bind.
// Depends on cdcq_pkg and coalescing_deferred_call_queue_assert.svh.
`include "coalescing_deferred_call_queue_assert.svh"

module cdcq_checker
    import cdcq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tlast
);

    // a stalled result beat holds
    `CDCQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // one command at a time: ready drops after an accepted beat
    `CDCQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "command accepted while busy")

    // enqueue and empty-drain results are single last beats with no payload
    `CDCQ_ASSERT_NOW(a_status_beat, m_tvalid && (m_tuser != STATUS_DELIVERED), m_tlast && (m_tdata[ENTRY_W-1:0] == '0), "status beat not last or carries payload")

    // only queued or coalesced enqueues may request the soft interrupt
    `CDCQ_ASSERT_NOW(a_sir_source, m_tvalid && m_tdata[ENTRY_W], (m_tuser == STATUS_QUEUED) || (m_tuser == STATUS_COALESCED), "soft interrupt request on wrong status")

endmodule

bind coalescing_deferred_call_queue cdcq_checker u_cdcq_checker (.*);
